@@ rtl/core/rog_pkg.sv @@
// Package for the rectangle occupancy grid: board constants, item types,
// row-unit control types and mask helper functions.
// No dependencies.
package rog_pkg;

  // Board geometry
  localparam int BOARD_SIDE     = 56;
  localparam int MAX_RECT_WIDTH = 32;
  localparam int FIELD_W        = 6;
  localparam int WORD_W         = 64;

  localparam logic [FIELD_W-1:0] SIDE_C  = FIELD_W'(BOARD_SIDE);
  localparam logic [FIELD_W-1:0] MAXW_C  = FIELD_W'(MAX_RECT_WIDTH);

  // Request codes
  localparam logic [1:0] FUNC_PLACE  = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_FIND   = 2'd2;

  // Row unit operations
  localparam logic [1:0] RU_TEST = 2'd0;
  localparam logic [1:0] RU_SET  = 2'd1;
  localparam logic [1:0] RU_CLR  = 2'd2;
  localparam logic [1:0] RU_FIND = 2'd3;

  typedef logic [BOARD_SIDE-1:0] row_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [FIELD_W-1:0] rect_width;
    logic [FIELD_W-1:0] rect_height;
    logic [FIELD_W-1:0] pos_x;
    logic [FIELD_W-1:0] pos_y;
  } in_item_t;

  typedef struct packed {
    logic               placed;
    logic [FIELD_W-1:0] free_x;
    logic [FIELD_W-1:0] free_y;
    logic               board_full;
  } out_item_t;

  // Row store ports
  typedef struct packed {
    logic               en;
    logic [FIELD_W-1:0] addr;
  } row_rd_t;

  typedef struct packed {
    logic               en;
    logic [FIELD_W-1:0] addr;
    row_t               data;
  } row_wr_t;

  // Row unit request and response
  typedef struct packed {
    logic [1:0] op;
    row_t       mask;
  } ru_req_t;

  typedef struct packed {
    logic               hit;
    logic [FIELD_W-1:0] idx;
    row_t               row;
  } ru_rsp_t;

  // Rectangle span over a full 64-bit row word; width saturates
  function automatic logic [WORD_W-1:0] span_mask(input logic [FIELD_W-1:0] w,
                                                  input logic [FIELD_W-1:0] x);
    logic [FIELD_W-1:0] ws;
    logic [WORD_W-1:0]  m;
    ws = (w > MAXW_C) ? MAXW_C : w;
    m  = (WORD_W'(1) << ws) - WORD_W'(1);
    return m << x;
  endfunction

  // Columns at or above x, board columns only
  function automatic row_t scan_mask(input logic [FIELD_W-1:0] x);
    logic [WORD_W-1:0] m;
    m = ~((WORD_W'(1) << x) - WORD_W'(1));
    return m[BOARD_SIDE-1:0];
  endfunction

endpackage

@@ rtl/core/rog_row_store.sv @@
// Occupancy row memory: one board row word per entry, one read and one write
// port, registered read data, per-row valid bits so unwritten rows read empty.
// Depends on rog_pkg.
module rog_row_store (
  input  logic             clk,
  input  logic             rst_n,
  input  rog_pkg::row_rd_t rd,
  input  rog_pkg::row_wr_t wr,
  output rog_pkg::row_t    rd_data
);

  rog_pkg::row_t                      mem [rog_pkg::BOARD_SIDE];
  logic [rog_pkg::BOARD_SIDE-1:0]     vld_r;
  rog_pkg::row_t                      rd_data_r;

  // Row array write and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_data_r <= vld_r[rd.addr] ? mem[rd.addr] : '0;
    end
  end

  // Valid bits: cleared by reset, set on first write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/rog_row_unit.sv @@
// Shared row unit: overlap test, mark, clear and first-free search on one
// board row word per cycle.
// Depends on rog_pkg.
module rog_row_unit (
  input  rog_pkg::row_t    row,
  input  rog_pkg::ru_req_t req,
  output rog_pkg::ru_rsp_t rsp
);

  rog_pkg::row_t              cand;
  rog_pkg::row_t              iso;
  logic [rog_pkg::FIELD_W-1:0] idx;

  // Free cells under the scan mask, lowest one isolated
  assign cand = ~row & req.mask;
  assign iso  = cand & (~cand + rog_pkg::row_t'(1));

  // One-hot to index
  always_comb begin
    idx = '0;
    for (int p = 0; p < rog_pkg::BOARD_SIDE; p++) begin
      if (iso[p]) begin
        idx = idx | rog_pkg::FIELD_W'(p);
      end
    end
  end

  always_comb begin
    rsp     = '0;
    rsp.idx = idx;
    case (req.op)
      rog_pkg::RU_TEST: begin
        rsp.hit = |(row & req.mask);
        rsp.row = row;
      end
      rog_pkg::RU_SET: begin
        rsp.row = row | req.mask;
      end
      rog_pkg::RU_CLR: begin
        rsp.row = row & ~req.mask;
      end
      rog_pkg::RU_FIND: begin
        rsp.hit = |cand;
        rsp.row = row;
      end
      default: begin
        rsp.row = row;
      end
    endcase
  end

endmodule

@@ rtl/core/rect_occupancy_grid.sv @@
// Rectangle occupancy grid top level: request sequencer, row store, row unit
// and output register. Depends on rog_pkg, rog_row_store, rog_row_unit.
//
// The block keeps a 56x56 occupancy board and serves one request at a time.
// Every request that is not settled up front walks the board rows through a
// single row unit, one row word per cycle, each row word read from the row
// memory in the cycle before it reaches the row unit. A place request runs a
// test pass, then a mark pass; a place that fails stops at the first clashing
// row, and one that is settled up front (off the board, or empty) walks no
// rows. A remove walks the rows that lie on the board. A find stops when it
// hits a free cell, or runs off the bottom and reports the board full.
// in_stall stays high until the request is finished; the result then sits
// in an output register, so the next request can be taken while that result
// waits for the consumer.
module rect_occupancy_grid (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rog_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rog_pkg::out_item_t out_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MARK  = 3'd2;
  localparam logic [2:0] S_CLEAR = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  localparam int FW = rog_pkg::FIELD_W;

  logic [2:0]         state_r, state_nxt;
  logic [FW-1:0]      iss_r, iss_nxt;
  logic [FW-1:0]      end_r, end_nxt;
  logic [FW-1:0]      y_r, y_nxt;
  logic               pv_r, pv_nxt;
  logic [FW-1:0]      prow_r, prow_nxt;
  rog_pkg::row_t      mask_r, mask_nxt;
  rog_pkg::row_t      smask_r, smask_nxt;
  rog_pkg::out_item_t res_r, res_nxt;
  rog_pkg::out_item_t out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  rog_pkg::row_rd_t   rd;
  rog_pkg::row_wr_t   wr;
  rog_pkg::row_t      rd_data;
  rog_pkg::ru_req_t   ru_req;
  rog_pkg::ru_rsp_t   ru_rsp;

  logic                         walking;
  logic                         issue;
  logic                         done;
  logic                         in_acc;
  logic [rog_pkg::WORD_W-1:0]   span;
  logic [FW:0]                  y_end;

  rog_row_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd      (rd),
    .wr      (wr),
    .rd_data (rd_data)
  );

  rog_row_unit u_unit (
    .row (rd_data),
    .req (ru_req),
    .rsp (ru_rsp)
  );

  // Handshake and walk status
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign walking   = (state_r == S_CHECK) || (state_r == S_MARK) ||
                     (state_r == S_CLEAR) || (state_r == S_SCAN);
  assign issue     = walking && (iss_r < end_r);
  assign done      = !issue && !pv_r;

  assign span  = rog_pkg::span_mask(in_data.rect_width, in_data.pos_x);
  assign y_end = {1'b0, in_data.pos_y} + {1'b0, in_data.rect_height};

  // Row store ports
  always_comb begin
    rd.en   = issue;
    rd.addr = iss_r;
    wr.en   = pv_r && ((state_r == S_MARK) || (state_r == S_CLEAR));
    wr.addr = prow_r;
    wr.data = ru_rsp.row;
  end

  // Row unit operation per state
  always_comb begin
    ru_req.mask = mask_r;
    case (state_r)
      S_CHECK: ru_req.op = rog_pkg::RU_TEST;
      S_MARK:  ru_req.op = rog_pkg::RU_SET;
      S_CLEAR: ru_req.op = rog_pkg::RU_CLR;
      S_SCAN: begin
        ru_req.op   = rog_pkg::RU_FIND;
        ru_req.mask = (prow_r == y_r) ? smask_r : '1;
      end
      default: ru_req.op = rog_pkg::RU_TEST;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    iss_nxt       = iss_r;
    end_nxt       = end_r;
    y_nxt         = y_r;
    pv_nxt        = 1'b0;
    prow_nxt      = prow_r;
    mask_nxt      = mask_r;
    smask_nxt     = smask_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    // Read pipeline: one row issued per cycle while rows remain
    if (issue) begin
      pv_nxt   = 1'b1;
      prow_nxt = iss_r;
      iss_nxt  = iss_r + FW'(1);
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mask_nxt  = span[rog_pkg::BOARD_SIDE-1:0];
          smask_nxt = rog_pkg::scan_mask(in_data.pos_x);
          y_nxt     = in_data.pos_y;
          iss_nxt   = in_data.pos_y;
          res_nxt   = '0;
          state_nxt = S_FIN;
          case (in_data.func)
            rog_pkg::FUNC_PLACE: begin
              if (in_data.rect_height == '0 || in_data.rect_width == '0) begin
                res_nxt.placed = 1'b1;
              end else if (!(|span[rog_pkg::WORD_W-1:rog_pkg::BOARD_SIDE]) &&
                           y_end <= {1'b0, rog_pkg::SIDE_C}) begin
                end_nxt   = y_end[FW-1:0];
                state_nxt = S_CHECK;
              end
            end
            rog_pkg::FUNC_REMOVE: begin
              if (in_data.rect_height != '0 && in_data.rect_width != '0 &&
                  in_data.pos_y < rog_pkg::SIDE_C) begin
                end_nxt   = (y_end > {1'b0, rog_pkg::SIDE_C}) ? rog_pkg::SIDE_C
                                                              : y_end[FW-1:0];
                state_nxt = S_CLEAR;
              end
            end
            rog_pkg::FUNC_FIND: begin
              if (in_data.pos_y < rog_pkg::SIDE_C) begin
                end_nxt   = rog_pkg::SIDE_C;
                state_nxt = S_SCAN;
              end else begin
                res_nxt.free_y     = rog_pkg::SIDE_C;
                res_nxt.board_full = 1'b1;
              end
            end
            default: begin
              res_nxt = '0;
            end
          endcase
        end
      end
      S_CHECK: begin
        if (pv_r && ru_rsp.hit) begin
          pv_nxt    = 1'b0;
          state_nxt = S_FIN;
        end else if (done) begin
          iss_nxt   = y_r;
          state_nxt = S_MARK;
        end
      end
      S_MARK: begin
        if (done) begin
          res_nxt.placed = 1'b1;
          state_nxt      = S_FIN;
        end
      end
      S_CLEAR: begin
        if (done) begin
          state_nxt = S_FIN;
        end
      end
      S_SCAN: begin
        if (pv_r && ru_rsp.hit) begin
          res_nxt.free_x = ru_rsp.idx;
          res_nxt.free_y = prow_r;
          pv_nxt         = 1'b0;
          state_nxt      = S_FIN;
        end else if (done) begin
          res_nxt.free_y     = rog_pkg::SIDE_C;
          res_nxt.board_full = 1'b1;
          state_nxt          = S_FIN;
        end
      end
      S_FIN: begin
        // Hand the result to the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      iss_r       <= '0;
      end_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
      iss_r       <= iss_nxt;
      end_r       <= end_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    y_r     <= y_nxt;
    prow_r  <= prow_nxt;
    mask_r  <= mask_nxt;
    smask_r <= smask_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  // Row writes happen only in the mark and clear passes
  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (state_r == S_MARK || state_r == S_CLEAR))
    else $error("row write outside mark/clear pass");

  // Rows in flight are always on the board
  a_prow_range: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> (prow_r < rog_pkg::SIDE_C))
    else $error("row in flight beyond board");

  // Walk pointer never passes its end, end never passes the board
  a_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    walking |-> (iss_r <= end_r && end_r <= rog_pkg::SIDE_C))
    else $error("walk pointer out of range");

  // A full-board result carries the past-board coordinates
  a_full_coord: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.board_full) |->
      (out_r.free_y == rog_pkg::SIDE_C && out_r.free_x == '0 && !out_r.placed))
    else $error("full result with bad coordinates");

  // An accepted item moves the sequencer out of idle
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("sequencer stayed idle after accept");

endmodule
